// File: src/fc16_pkg.sv
package fc16_pkg;

	// One received byte and its end-of-frame flag.
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       is_last;
	} in_item_t;

	// One result: a payload byte or a frame verdict.
	typedef struct packed {
		logic       out_kind;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic       frame_ok;
		logic [1:0] error_code;
		logic [7:0] msg_type;
		logic [7:0] seq_num;
		logic [7:0] payload_length;
	} out_item_t;

	// Operations that the front hands to the back.
	typedef enum logic [2:0] {
		OP_TYPE    = 3'd0,
		OP_SEQ     = 3'd1,
		OP_LEN     = 3'd2,
		OP_PAYLOAD = 3'd3,
		OP_CRC_HI  = 3'd4,
		OP_VERDICT = 3'd5
	} op_t;

	// One classified request in the queue between front and back.
	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic [7:0] index;
		logic [1:0] err;
	} req_t;

	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'h1021;
	localparam logic [15:0] CRC_TOP   = 16'h8000;
	localparam logic [8:0]  COUNT_MAX = 9'd511;
	localparam logic [8:0]  HDR_LEN   = 9'd3;
	localparam logic [9:0]  MIN_FRAME = 10'd5;

	localparam logic [1:0] ERR_OK     = 2'd0;
	localparam logic [1:0] ERR_SHORT  = 2'd1;
	localparam logic [1:0] ERR_LENGTH = 2'd2;
	localparam logic [1:0] ERR_CRC    = 2'd3;

	localparam logic OUT_PAYLOAD = 1'b0;
	localparam logic OUT_VERDICT = 1'b1;

	// Byte-parallel CRC-16/CCITT-FALSE update, most significant bit first.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if ((c & CRC_TOP) != 16'h0000) begin
				c = (c << 1) ^ CRC_POLY;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

endpackage

// File: src/fc16_front.sv
module fc16_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  fc16_pkg::in_item_t item,
	output logic              req_push,
	output fc16_pkg::req_t    req
);

	localparam logic [8:0] HDR_LEN_EXT = fc16_pkg::HDR_LEN;

	logic [8:0] count_q;
	logic [7:0] length_q;
	logic [9:0] crc_pos;
	logic [9:0] total;
	logic [9:0] expected;
	logic       in_payload;
	logic       useful;
	logic [8:0] index_full;

	// Position bookkeeping for the current frame.
	assign crc_pos    = {1'b0, HDR_LEN_EXT} + {2'b00, length_q};
	assign total      = {1'b0, count_q} + 10'd1;
	assign expected   = {2'b00, length_q} + fc16_pkg::MIN_FRAME;
	assign in_payload = (count_q >= fc16_pkg::HDR_LEN) && ({1'b0, count_q} < crc_pos);
	assign index_full = count_q - fc16_pkg::HDR_LEN;

	// Classify the incoming byte.
	always_comb begin
		req.data  = item.rx_byte;
		req.index = index_full[7:0];
		req.err   = fc16_pkg::ERR_OK;
		req.op    = fc16_pkg::OP_VERDICT;
		useful    = 1'b1;
		if (item.is_last) begin
			req.op = fc16_pkg::OP_VERDICT;
			if (total < fc16_pkg::MIN_FRAME) begin
				req.err = fc16_pkg::ERR_SHORT;
			end else if (total != expected) begin
				req.err = fc16_pkg::ERR_LENGTH;
			end else begin
				req.err = fc16_pkg::ERR_OK;
			end
		end else if (count_q == 9'd0) begin
			req.op = fc16_pkg::OP_TYPE;
		end else if (count_q == 9'd1) begin
			req.op = fc16_pkg::OP_SEQ;
		end else if (count_q == 9'd2) begin
			req.op = fc16_pkg::OP_LEN;
		end else if (in_payload) begin
			req.op = fc16_pkg::OP_PAYLOAD;
		end else if ({1'b0, count_q} == crc_pos) begin
			req.op = fc16_pkg::OP_CRC_HI;
		end else begin
			// Low CRC byte not flagged last, or trailing bytes: nothing to do.
			useful = 1'b0;
		end
	end

	assign req_push = accept && useful;

	// Byte counter, saturating on overlong frames.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 9'd0;
		end else if (accept) begin
			if (item.is_last) begin
				count_q <= 9'd0;
			end else if (count_q != fc16_pkg::COUNT_MAX) begin
				count_q <= count_q + 9'd1;
			end
		end
	end

	// The length field is held here, since classification depends on it.
	always_ff @(posedge clk) begin
		if (accept && !item.is_last && (count_q == 9'd2)) begin
			length_q <= item.rx_byte;
		end
	end

endmodule

// File: src/fc16_queue.sv
module fc16_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fc16_pkg::req_t wr_req,
	input  logic           pop,
	output fc16_pkg::req_t head,
	output logic           full,
	output logic           empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

	fc16_pkg::req_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	// Storage for queued requests.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_req;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// File: src/fc16_back.sv
module fc16_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_empty,
	input  fc16_pkg::req_t      req,
	output logic                req_pop,
	input  logic                pop,
	output logic                empty,
	output fc16_pkg::out_item_t result
);

	logic [15:0]         crc_q;
	logic [7:0]          type_q;
	logic [7:0]          seq_q;
	logic [7:0]          len_q;
	logic [7:0]          crc_hi_q;
	logic                out_valid_q;
	fc16_pkg::out_item_t result_q;
	fc16_pkg::out_item_t next_result;
	logic                produces;
	logic                ready;
	logic [1:0]          err;

	// The output slot frees up when its result is taken.
	assign ready   = !out_valid_q || pop;
	assign req_pop = !req_empty && ready;
	assign empty   = !out_valid_q;
	assign result  = result_q;

	// Final error code, adding the CRC check to the front's length checks.
	always_comb begin
		if (req.err != fc16_pkg::ERR_OK) begin
			err = req.err;
		end else if ({crc_hi_q, req.data} != crc_q) begin
			err = fc16_pkg::ERR_CRC;
		end else begin
			err = fc16_pkg::ERR_OK;
		end
	end

	// Build the result for the request at the head of the queue.
	always_comb begin
		next_result = '0;
		produces    = 1'b0;
		case (req.op)
			fc16_pkg::OP_PAYLOAD: begin
				produces                  = 1'b1;
				next_result.out_kind      = fc16_pkg::OUT_PAYLOAD;
				next_result.payload_byte  = req.data;
				next_result.payload_index = req.index;
			end
			fc16_pkg::OP_VERDICT: begin
				produces               = 1'b1;
				next_result.out_kind   = fc16_pkg::OUT_VERDICT;
				next_result.error_code = err;
				if (err == fc16_pkg::ERR_OK) begin
					next_result.frame_ok       = 1'b1;
					next_result.msg_type       = type_q;
					next_result.seq_num        = seq_q;
					next_result.payload_length = len_q;
				end
			end
			default: begin
				produces = 1'b0;
			end
		endcase
	end

	// Running CRC over header and payload, restarted after each verdict.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= fc16_pkg::CRC_INIT;
		end else if (req_pop) begin
			case (req.op)
				fc16_pkg::OP_TYPE, fc16_pkg::OP_SEQ, fc16_pkg::OP_LEN,
				fc16_pkg::OP_PAYLOAD: begin
					crc_q <= fc16_pkg::crc_byte(crc_q, req.data);
				end
				fc16_pkg::OP_VERDICT: begin
					crc_q <= fc16_pkg::CRC_INIT;
				end
				default: begin
					crc_q <= crc_q;
				end
			endcase
		end
	end

	// Header fields and the high CRC byte.
	always_ff @(posedge clk) begin
		if (req_pop) begin
			case (req.op)
				fc16_pkg::OP_TYPE:   type_q   <= req.data;
				fc16_pkg::OP_SEQ:    seq_q    <= req.data;
				fc16_pkg::OP_LEN:    len_q    <= req.data;
				fc16_pkg::OP_CRC_HI: crc_hi_q <= req.data;
				default: begin
				end
			endcase
		end
	end

	// Output register holding the oldest waiting result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (req_pop && produces) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_pop && produces) begin
			result_q <= next_result;
		end
	end

endmodule

// File: src/frame_checker_crc16.sv
// A byte's result is registered in the middle queue and then the output register.
// Throughput: one byte per cycle while the middle queue has room, set by the
// byte-parallel CRC update; header, high CRC and trailing bytes give no result.
// Up to QUEUE_DEPTH classified bytes plus one result are buffered under stall.
// Reset (arst_n low, asynchronous) empties the queue and the output register,
// zeroes the byte count and loads the CRC with its initial value.
module frame_checker_crc16 #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  fc16_pkg::in_item_t  item,
	output logic                empty,
	input  logic                pop,
	output fc16_pkg::out_item_t result
);

	fc16_pkg::req_t front_req;
	fc16_pkg::req_t head_req;
	logic           front_push;
	logic           mid_full;
	logic           mid_empty;
	logic           mid_pop;
	logic           accept;

	// A request is taken whenever the middle queue has room.
	assign full   = mid_full;
	assign accept = push && !mid_full;

	fc16_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.req_push (front_push),
		.req      (front_req)
	);

	fc16_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_push),
		.wr_req (front_req),
		.pop    (mid_pop),
		.head   (head_req),
		.full   (mid_full),
		.empty  (mid_empty)
	);

	fc16_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_empty (mid_empty),
		.req       (head_req),
		.req_pop   (mid_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

// File: src/fc16_checker.sv
module fc16_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                full,
	input logic                empty,
	input logic                pop,
	input fc16_pkg::out_item_t result
);

	// Nothing is offered while reset is held.
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> empty)
		else $error("result offered during reset");

	// The input side only backs up when a result is waiting to be taken.
	a_full_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("input stalled with no result waiting");

	// A result that is not taken stays on the ports unchanged.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed or vanished");

	// A passing verdict is a verdict with no error.
	a_ok_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.frame_ok) |->
		(result.out_kind == fc16_pkg::OUT_VERDICT && result.error_code == fc16_pkg::ERR_OK))
		else $error("frame_ok set on an inconsistent result");

endmodule

bind frame_checker_crc16 fc16_checker u_fc16_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam logic [15:0] CRC16_INIT = 16'hFFFF;
	localparam logic [15:0] CRC16_POLY = 16'h1021;
	localparam int MIN_FRAME_BYTES = 5;
	localparam int COUNT_CEILING = 511;
	localparam int SETTLE_CYCLES = 4;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	fc16_pkg::in_item_t item = '0;
	logic empty;
	logic pop = 1'b0;
	fc16_pkg::out_item_t result;

	// Predicted state of the frame checker.
	int unsigned frame_pos;
	logic [15:0] frame_crc;
	logic [7:0] held_type;
	logic [7:0] held_seq;
	logic [7:0] held_len;
	logic [15:0] held_rx_crc;

	fc16_pkg::out_item_t pending_results[$];
	logic [7:0] frame_bytes[$];

	int gap_pct = 0;
	int stall_pct = 0;
	int rx_hold_cycles = 0;
	int mismatch_count = 0;
	int bytes_sent = 0;
	int frames_sent = 0;
	int payload_seen = 0;
	int verdicts_seen = 0;
	int verdicts_good = 0;
	int cycle_count = 0;

	frame_checker_crc16 DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	// Free-running clock, 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog on the total length of the run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycle_count, pending_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// CRC-16/CCITT-FALSE, shifted one bit at a time from the most significant end.
	function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ b[i];
			c = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ CRC16_POLY;
			end
		end
		return c;
	endfunction

	function automatic void clear_prediction();
		frame_pos = 0;
		frame_crc = CRC16_INIT;
		held_type = '0;
		held_seq = '0;
		held_len = '0;
		held_rx_crc = '0;
	endfunction

	// Advances the predicted state by one byte; returns 1 when the byte yields a result.
	function automatic logic predict_frame_byte(input fc16_pkg::in_item_t req,
		output fc16_pkg::out_item_t res);
		int unsigned plen;
		int unsigned total;
		logic in_payload;
		logic [1:0] err;
		plen = held_len;
		in_payload = (frame_pos >= 3) && (frame_pos < 3 + plen);
		res = '0;

		// The last byte closes the frame with a verdict and nothing else.
		if (req.is_last) begin
			total = frame_pos + 1;
			res.out_kind = fc16_pkg::OUT_VERDICT;
			if (total < MIN_FRAME_BYTES) begin
				err = fc16_pkg::ERR_SHORT;
			end else if (total != plen + 5) begin
				err = fc16_pkg::ERR_LENGTH;
			end else if ({held_rx_crc[15:8], req.rx_byte} == frame_crc) begin
				err = fc16_pkg::ERR_OK;
			end else begin
				err = fc16_pkg::ERR_CRC;
			end
			res.error_code = err;
			if (err == fc16_pkg::ERR_OK) begin
				res.frame_ok = 1'b1;
				res.msg_type = held_type;
				res.seq_num = held_seq;
				res.payload_length = held_len;
			end
			frame_pos = 0;
			frame_crc = CRC16_INIT;
			return 1'b1;
		end

		// Header and payload bytes feed the CRC; trailing bytes do not.
		if (frame_pos <= 2 || in_payload) begin
			frame_crc = crc16_next(frame_crc, req.rx_byte);
		end
		if (frame_pos == 0) begin
			held_type = req.rx_byte;
		end else if (frame_pos == 1) begin
			held_seq = req.rx_byte;
		end else if (frame_pos == 2) begin
			held_len = req.rx_byte;
		end else if (frame_pos == 3 + plen) begin
			held_rx_crc = {req.rx_byte, 8'h00};
		end
		if (frame_pos < COUNT_CEILING) begin
			frame_pos++;
		end

		// The counter has already moved past this payload byte.
		if (in_payload) begin
			res.out_kind = fc16_pkg::OUT_PAYLOAD;
			res.payload_byte = req.rx_byte;
			res.payload_index = 8'(frame_pos - 4);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Checks each accepted result against the oldest prediction.
	always @(posedge clk) begin
		fc16_pkg::out_item_t want;
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				$error("Result with no request waiting for one: kind %0d", result.out_kind);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("out_kind", 8'(want.out_kind), 8'(result.out_kind));
				check_field("payload_byte", want.payload_byte, result.payload_byte);
				check_field("payload_index", want.payload_index, result.payload_index);
				check_field("frame_ok", 8'(want.frame_ok), 8'(result.frame_ok));
				check_field("error_code", 8'(want.error_code), 8'(result.error_code));
				check_field("msg_type", want.msg_type, result.msg_type);
				check_field("seq_num", want.seq_num, result.seq_num);
				check_field("payload_length", want.payload_length, result.payload_length);
				if (want.out_kind == fc16_pkg::OUT_PAYLOAD) begin
					payload_seen++;
				end else begin
					verdicts_seen++;
					if (want.frame_ok) begin
						verdicts_good++;
					end
				end
			end
		end
	end

	// A requested hold keeps pop low until rx_hold_cycles runs down, otherwise stall at random.
	always @(posedge clk) begin
		if (rx_hold_cycles > 0) begin
			rx_hold_cycles--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Offers one byte, with random idle cycles first, and predicts once it is taken.
	task automatic send_request(input logic [7:0] b, input logic last);
		fc16_pkg::in_item_t req;
		fc16_pkg::out_item_t res;
		req.rx_byte = b;
		req.is_last = last;
		while ($urandom_range(99) < gap_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		item <= req;
		push <= 1'b1;
		do begin
			@(posedge clk);
		end while (full);
		if (predict_frame_byte(req, res)) begin
			pending_results.push_back(res);
		end
		bytes_sent++;
	endtask

	task automatic send_frame();
		foreach (frame_bytes[i]) begin
			send_request(frame_bytes[i], i == frame_bytes.size() - 1);
		end
		frames_sent++;
	endtask

	// Builds a well-formed frame; a negative fill gives random payload bytes.
	function automatic void build_frame(input logic [7:0] kind, input logic [7:0] seq,
		input int len, input int fill);
		logic [15:0] crc;
		frame_bytes.delete();
		frame_bytes.push_back(kind);
		frame_bytes.push_back(seq);
		frame_bytes.push_back(8'(len));
		for (int i = 0; i < len; i++) begin
			frame_bytes.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
		end
		crc = CRC16_INIT;
		foreach (frame_bytes[i]) begin
			crc = crc16_next(crc, frame_bytes[i]);
		end
		frame_bytes.push_back(crc[15:8]);
		frame_bytes.push_back(crc[7:0]);
	endfunction

	// The sender stops and waits until every predicted result has been taken.
	task automatic wait_for_drain();
		push <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_short_frames();
		gap_pct = 0;
		stall_pct = 0;
		frame_bytes = '{8'hFF};
		send_frame();
		frame_bytes = '{8'h00, 8'hFF};
		send_frame();
		frame_bytes = '{8'hFF, 8'h00, 8'hFF};
		send_frame();
		// Four bytes ending on a payload position still counts as too short.
		frame_bytes = '{8'h00, 8'hFF, 8'h05, 8'hAA};
		send_frame();
		wait_for_drain();
	endtask

	task automatic test_good_frames();
		build_frame(8'h00, 8'h00, 0, 0);
		send_frame();
		build_frame(8'hFF, 8'hFF, 1, 8'hFF);
		send_frame();
		build_frame(8'hA5, 8'h5A, 3, 8'h00);
		send_frame();
		// Longest payload reaches the top payload index.
		build_frame(8'h7F, 8'h80, 255, -1);
		send_frame();
		wait_for_drain();
	endtask

	task automatic test_broken_frames();
		gap_pct = 11;
		stall_pct = 11;
		build_frame(8'h3C, 8'h01, 4, -1);
		frame_bytes[frame_bytes.size() - 1] ^= 8'h01;
		send_frame();
		build_frame(8'h3C, 8'h02, 4, -1);
		frame_bytes[frame_bytes.size() - 2] ^= 8'h80;
		send_frame();
		// Last byte lands inside the payload: length mismatch, that byte not passed on.
		build_frame(8'h10, 8'h03, 4, -1);
		repeat (4) void'(frame_bytes.pop_back());
		send_frame();
		// Five bytes but the length field asks for six.
		build_frame(8'h20, 8'h04, 1, 8'hFF);
		void'(frame_bytes.pop_back());
		send_frame();
		// Trailing bytes after the CRC.
		build_frame(8'h30, 8'h05, 2, 8'h00);
		frame_bytes.push_back(8'h12);
		frame_bytes.push_back(8'h34);
		send_frame();
		// Corrupted header byte gives a CRC mismatch.
		build_frame(8'h40, 8'h06, 3, -1);
		frame_bytes[0] ^= 8'h80;
		send_frame();
		wait_for_drain();
	endtask

	task automatic test_overlong_frame();
		gap_pct = 0;
		stall_pct = 0;
		build_frame(8'h55, 8'hAA, 10, -1);
		while (frame_bytes.size() < 530) begin
			frame_bytes.push_back(8'($urandom));
		end
		send_frame();
		wait_for_drain();
	endtask

	// The receiver holds off while payload keeps coming, so the input must stall.
	task automatic test_backpressure();
		gap_pct = 0;
		stall_pct = 0;
		rx_hold_cycles = 60;
		build_frame(8'h66, 8'h07, 40, -1);
		send_frame();
		build_frame(8'h67, 8'h08, 20, -1);
		send_frame();
		wait_for_drain();
		build_frame(8'h68, 8'h09, 5, -1);
		send_frame();
		wait_for_drain();
	endtask

	// Mostly well-formed frames with random content, plus broken frames and noise.
	task automatic send_random_frame();
		int pick;
		int len;
		int k;
		int idx;
		pick = $urandom_range(99);
		len = ($urandom_range(9) == 0) ? $urandom_range(13, 80) : $urandom_range(0, 12);
		if (pick < 8) begin
			frame_bytes.delete();
			k = $urandom_range(1, 8);
			repeat (k) frame_bytes.push_back(8'($urandom));
		end else begin
			build_frame(8'($urandom), 8'($urandom), len, -1);
			if (pick < 18) begin
				idx = frame_bytes.size() - 1 - $urandom_range(1);
				frame_bytes[idx] ^= (8'h01 << $urandom_range(7));
			end else if (pick < 24) begin
				idx = $urandom_range(frame_bytes.size() - 3);
				frame_bytes[idx] ^= (8'h01 << $urandom_range(7));
			end else if (pick < 32) begin
				k = $urandom_range(1, frame_bytes.size() - 1);
				repeat (k) void'(frame_bytes.pop_back());
			end else if (pick < 38) begin
				k = $urandom_range(1, 4);
				repeat (k) frame_bytes.push_back(8'($urandom));
			end
		end
		send_frame();
	endtask

	task automatic test_random_traffic(input int gap, input int stall, input int budget);
		int start;
		gap_pct = gap;
		stall_pct = stall;
		start = bytes_sent;
		while (bytes_sent - start < budget) begin
			send_random_frame();
		end
		wait_for_drain();
	endtask

	initial begin
		clear_prediction();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_short_frames();
		test_good_frames();
		test_broken_frames();
		test_overlong_frame();
		test_backpressure();
		test_random_traffic(0, 0, 235);
		test_random_traffic(50, 0, 235);
		test_random_traffic(0, 50, 235);
		test_random_traffic(11, 11, 235);

		if (pending_results.size() != 0) begin
			$error("%0d predicted results never arrived", pending_results.size());
			mismatch_count++;
		end
		$display("Sent %0d frames in %0d bytes: good, short, length and CRC failures,",
			frames_sent, bytes_sent);
		$display("trailing and overlong frames; %0d payload bytes, %0d verdicts (%0d good).",
			payload_seen, verdicts_seen, verdicts_good);
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// File: filelist.f
src/fc16_pkg.sv
src/fc16_front.sv
src/fc16_queue.sv
src/fc16_back.sv
src/frame_checker_crc16.sv
src/fc16_checker.sv
tb/tb_top.sv
